/* rtl/core/qf_pkg.sv */
package qf_pkg;

  localparam int MIN_QBITS = 6;
  localparam int FLAG_BITS = 3;
  localparam int F_OCC = 0;
  localparam int F_CONT = 1;
  localparam int F_SHIFT = 2;

  localparam logic [1:0] ACT_ADD = 2'd0;
  localparam logic [1:0] ACT_QUERY = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  localparam logic [2:0] OUT_ABSENT = 3'd0;
  localparam logic [2:0] OUT_PRESENT = 3'd1;
  localparam logic [2:0] OUT_INSERTED = 3'd2;
  localparam logic [2:0] OUT_FULL = 3'd3;
  localparam logic [2:0] OUT_CLEARED = 3'd4;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_QUERY,
    OP_CLEAR,
    OP_NOP
  } op_t;

  typedef struct packed {
    logic init;
    logic idle;
  } eng_status_t;

endpackage

/* rtl/core/qf_front.sv */
module qf_front #(
  parameter int MAX_QUOTIENT_BITS = 12,
  parameter int REMAINDER_BITS = 1
) (
  input  logic                                  start,
  output logic                                  busy,
  input  logic [1:0]                            action,
  input  logic [63:0]                           hash,
  input  logic [MAX_QUOTIENT_BITS-1:0]          mask_now,
  input  qf_pkg::eng_status_t                   status,
  input  logic                                  queue_full,
  output logic                                  push,
  output qf_pkg::op_t                           push_op,
  output logic [MAX_QUOTIENT_BITS-1:0]          push_fq,
  output logic [REMAINDER_BITS-1:0]             push_fr
);
  import qf_pkg::*;

  assign busy = queue_full || status.init;
  assign push = start && !busy;
  assign push_fq = hash[REMAINDER_BITS +: MAX_QUOTIENT_BITS] & mask_now;
  assign push_fr = hash[REMAINDER_BITS-1:0];

  always_comb begin
    unique case (action)
      ACT_ADD:   push_op = OP_ADD;
      ACT_QUERY: push_op = OP_QUERY;
      ACT_CLEAR: push_op = OP_CLEAR;
      default:   push_op = OP_NOP;
    endcase
  end

endmodule

/* rtl/core/qf_queue.sv */
module qf_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             nonempty
);

  logic [WIDTH-1:0] entries [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;

  assign full = (fill == 2'd2);
  assign nonempty = (fill != 2'd0);
  assign dout = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= din;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

/* rtl/core/qf_engine.sv */
module qf_engine #(
  parameter int MAX_QUOTIENT_BITS = 12,
  parameter int REMAINDER_BITS = 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cmd_valid,
  input  qf_pkg::op_t                    cmd_op,
  input  logic [MAX_QUOTIENT_BITS-1:0]   cmd_fq,
  input  logic [REMAINDER_BITS-1:0]      cmd_fr,
  output logic                           cmd_pop,
  input  logic [MAX_QUOTIENT_BITS:0]     size_now,
  input  logic [MAX_QUOTIENT_BITS-1:0]   mask_now,
  output logic                           done,
  output logic [2:0]                     outcome,
  output qf_pkg::eng_status_t            status
);
  import qf_pkg::*;

  localparam int QW = MAX_QUOTIENT_BITS;
  localparam int RW = REMAINDER_BITS;
  localparam int WW = RW + FLAG_BITS;
  localparam int CW = QW + 1;
  localparam int DEPTH = 1 << QW;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_HOME, S_QHOME, S_RS_GO, S_RS_B, S_RS_OUT, S_RS_S, S_RS_BB,
    S_SCAN, S_CONT_RD, S_SH_GO, S_SH, S_CLEAR
  } state_t;

  logic [WW-1:0] mem [DEPTH];
  logic [WW-1:0] mem_q;
  logic [QW-1:0] raddr;
  logic          we;
  logic [QW-1:0] waddr;
  logic [WW-1:0] wdata;

  state_t        state, state_next;
  op_t           op, op_next;
  logic [QW-1:0] fq, fq_next;
  logic [RW-1:0] fr, fr_next;
  logic [WW-1:0] word, word_next;
  logic [WW-1:0] cur, cur_next;
  logic          home_occ, home_occ_next;
  logic          first, first_next;
  logic [QW-1:0] b, b_next;
  logic [QW-1:0] s, s_next;
  logic [QW-1:0] start_s, start_s_next;
  logic [CW-1:0] n, n_next;
  logic [CW-1:0] k, k_next;
  logic [CW-1:0] count, count_next;
  logic [QW-1:0] clr_addr, clr_addr_next;
  logic          done_next;
  logic [2:0]    outcome_next;

  logic [QW-1:0] s_inc, b_inc, b_dec;
  logic [CW-1:0] n_inc;
  logic [RW-1:0] rem;
  logic          scan_go;
  logic [WW-1:0] old_m, cur_m;
  logic          old_empty;

  assign s_inc = (s + 1'b1) & mask_now;
  assign b_inc = (b + 1'b1) & mask_now;
  assign b_dec = (b - 1'b1) & mask_now;
  assign n_inc = n + 1'b1;
  assign rem = mem_q[WW-1:FLAG_BITS];
  assign scan_go = first || (mem_q[F_CONT] && (n < size_now));
  assign old_empty = (mem_q[FLAG_BITS-1:0] == '0);

  assign status.init = (state == S_INIT);
  assign status.idle = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    mem_q <= mem[raddr];
  end

  always_comb begin
    old_m = mem_q;
    cur_m = cur;
    if (!old_empty) begin
      old_m[F_SHIFT] = 1'b1;
      if (old_m[F_OCC]) begin
        cur_m[F_OCC] = 1'b1;
        old_m[F_OCC] = 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    op_next = op;
    fq_next = fq;
    fr_next = fr;
    word_next = word;
    cur_next = cur;
    home_occ_next = home_occ;
    first_next = first;
    b_next = b;
    s_next = s;
    start_s_next = start_s;
    n_next = n;
    k_next = k;
    count_next = count;
    clr_addr_next = clr_addr;
    done_next = 1'b0;
    outcome_next = outcome;
    cmd_pop = 1'b0;
    raddr = s;
    we = 1'b0;
    waddr = s;
    wdata = cur;
    unique case (state)
      S_INIT, S_CLEAR: begin
        we = 1'b1;
        waddr = clr_addr;
        wdata = '0;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == QW'(DEPTH - 1)) begin
          count_next = '0;
          state_next = S_IDLE;
          if (state == S_CLEAR) begin
            done_next = 1'b1;
            outcome_next = OUT_CLEARED;
          end
        end
      end
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          op_next = cmd_op;
          fq_next = cmd_fq;
          fr_next = cmd_fr;
          word_next = {cmd_fr, FLAG_BITS'(0)};
          raddr = cmd_fq;
          unique case (cmd_op)
            OP_ADD: begin
              if (count >= size_now) begin
                done_next = 1'b1;
                outcome_next = OUT_FULL;
              end else begin
                state_next = S_HOME;
              end
            end
            OP_QUERY: state_next = S_QHOME;
            OP_CLEAR: begin
              clr_addr_next = '0;
              state_next = S_CLEAR;
            end
            default: begin
              done_next = 1'b1;
              outcome_next = OUT_ABSENT;
            end
          endcase
        end
      end
      S_HOME: begin
        home_occ_next = mem_q[F_OCC];
        waddr = fq;
        if (old_empty) begin
          we = 1'b1;
          wdata = word | WW'(1 << F_OCC);
          count_next = count + 1'b1;
          done_next = 1'b1;
          outcome_next = OUT_INSERTED;
          state_next = S_IDLE;
        end else begin
          if (!mem_q[F_OCC]) begin
            we = 1'b1;
            wdata = mem_q | WW'(1 << F_OCC);
          end
          state_next = S_RS_GO;
        end
      end
      S_QHOME: begin
        if (!mem_q[F_OCC]) begin
          done_next = 1'b1;
          outcome_next = OUT_ABSENT;
          state_next = S_IDLE;
        end else begin
          state_next = S_RS_GO;
        end
      end
      S_RS_GO: begin
        raddr = fq;
        b_next = fq;
        n_next = '0;
        state_next = S_RS_B;
      end
      S_RS_B: begin
        if (mem_q[F_SHIFT] && (n < size_now)) begin
          b_next = b_dec;
          raddr = b_dec;
          n_next = n_inc;
        end else begin
          s_next = b;
          n_next = '0;
          state_next = S_RS_OUT;
        end
      end
      S_RS_OUT: begin
        if ((b != fq) && (n < size_now)) begin
          s_next = s_inc;
          raddr = s_inc;
          k_next = CW'(1);
          state_next = S_RS_S;
        end else begin
          start_s_next = s;
          n_next = '0;
          first_next = 1'b1;
          raddr = s;
          if (op == OP_ADD && !home_occ) begin
            state_next = S_SH_GO;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_RS_S: begin
        if (mem_q[F_CONT] && (k < size_now)) begin
          s_next = s_inc;
          raddr = s_inc;
          k_next = k + 1'b1;
        end else begin
          b_next = b_inc;
          raddr = b_inc;
          k_next = CW'(1);
          state_next = S_RS_BB;
        end
      end
      S_RS_BB: begin
        if (!mem_q[F_OCC] && (k < size_now)) begin
          b_next = b_inc;
          raddr = b_inc;
          k_next = k + 1'b1;
        end else begin
          n_next = n_inc;
          state_next = S_RS_OUT;
        end
      end
      S_SCAN: begin
        if (scan_go && (rem == fr)) begin
          done_next = 1'b1;
          outcome_next = OUT_PRESENT;
          state_next = S_IDLE;
        end else if (scan_go && (rem < fr)) begin
          s_next = s_inc;
          raddr = s_inc;
          n_next = n_inc;
          first_next = 1'b0;
        end else if (op == OP_QUERY) begin
          done_next = 1'b1;
          outcome_next = OUT_ABSENT;
          state_next = S_IDLE;
        end else if (s == start_s) begin
          raddr = start_s;
          state_next = S_CONT_RD;
        end else begin
          word_next = word | WW'(1 << F_CONT);
          state_next = S_SH_GO;
        end
      end
      S_CONT_RD: begin
        we = 1'b1;
        waddr = start_s;
        wdata = mem_q | WW'(1 << F_CONT);
        state_next = S_SH_GO;
      end
      S_SH_GO: begin
        cur_next = (s != fq) ? (word | WW'(1 << F_SHIFT)) : word;
        raddr = s;
        n_next = '0;
        state_next = S_SH;
      end
      S_SH: begin
        we = 1'b1;
        waddr = s;
        wdata = cur_m;
        cur_next = old_m;
        s_next = s_inc;
        raddr = s_inc;
        n_next = n_inc;
        if (old_empty || (n_inc >= size_now)) begin
          count_next = count + 1'b1;
          done_next = 1'b1;
          outcome_next = OUT_INSERTED;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    op <= op_next;
    fq <= fq_next;
    fr <= fr_next;
    word <= word_next;
    cur <= cur_next;
    home_occ <= home_occ_next;
    first <= first_next;
    b <= b_next;
    s <= s_next;
    start_s <= start_s_next;
    n <= n_next;
    k <= k_next;
    outcome <= outcome_next;
    if (rst) begin
      state <= S_INIT;
      clr_addr <= '0;
      count <= '0;
      done <= 1'b0;
    end else begin
      state <= state_next;
      clr_addr <= clr_addr_next;
      count <= count_next;
      done <= done_next;
    end
  end

endmodule

/* rtl/core/quotient_filter_unit.sv */
// Quotient filter for approximate set membership over 64-bit key hashes.
// Command channel: present action and hash with start; a beat is taken at a
// rising edge where start is high and busy is low. Action add inserts the
// hash, query tests it, clear empties the table.
// Result channel: outcome is valid for exactly one cycle while done is high.
// The receiver cannot stall, so no result is ever held back.
// Configuration: quotient_bits is written through cfg_valid, cfg_ready and
// cfg_data; the user must write it only while the block is idle, which the
// block does not enforce; clear the table after a change. A two-beat
// command queue sits between the decoder and the table engine.
// A query whose home slot is not occupied, and an add into an empty home
// slot, finish once the home slot is read; other adds and queries then
// walk the cluster and scan the run, and adds also shift the run. The table
// is read one slot per cycle through the single registered read port.
// A clear writes every one of the 2^MAX_QUOTIENT_BITS slots. One item is
// worked on at a time. After reset the table is swept empty, with busy held
// high; configuration writes are taken during that sweep.
module quotient_filter_unit #(
  parameter int MAX_QUOTIENT_BITS = 12,
  parameter int REMAINDER_BITS = 1
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic [63:0] hash,
  output logic        done,
  output logic [2:0]  outcome,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data
);
  import qf_pkg::*;

  localparam int QW = MAX_QUOTIENT_BITS;
  localparam int RW = REMAINDER_BITS;
  localparam int CW = QW + 1;
  localparam int PW = 2 + QW + RW;

  logic [3:0]    quotient_bits;
  logic [4:0]    q_eff;
  logic [CW-1:0] size_now;
  logic [QW-1:0] mask_now;

  eng_status_t   eng_status;
  logic          queue_full;
  logic          push;
  op_t           push_op;
  logic [QW-1:0] push_fq;
  logic [RW-1:0] push_fr;
  logic [PW-1:0] q_dout;
  logic          q_nonempty;
  logic          cmd_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      quotient_bits <= 4'(MIN_QBITS);
    end else if (cfg_valid && cfg_ready) begin
      quotient_bits <= cfg_data;
    end
  end

  always_comb begin
    if (int'(quotient_bits) < MIN_QBITS) begin
      q_eff = 5'(MIN_QBITS);
    end else if (int'(quotient_bits) > QW) begin
      q_eff = 5'(QW);
    end else begin
      q_eff = 5'(quotient_bits);
    end
  end

  assign size_now = CW'(1) << q_eff;
  assign mask_now = QW'(size_now - 1'b1);

  qf_front #(
    .MAX_QUOTIENT_BITS(MAX_QUOTIENT_BITS),
    .REMAINDER_BITS(REMAINDER_BITS)
  ) u_front (
    .start(start),
    .busy(busy),
    .action(action),
    .hash(hash),
    .mask_now(mask_now),
    .status(eng_status),
    .queue_full(queue_full),
    .push(push),
    .push_op(push_op),
    .push_fq(push_fq),
    .push_fr(push_fr)
  );

  qf_queue #(
    .WIDTH(PW)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .din({push_op, push_fq, push_fr}),
    .full(queue_full),
    .pop(cmd_pop),
    .dout(q_dout),
    .nonempty(q_nonempty)
  );

  qf_engine #(
    .MAX_QUOTIENT_BITS(MAX_QUOTIENT_BITS),
    .REMAINDER_BITS(REMAINDER_BITS)
  ) u_engine (
    .clk(clk),
    .rst(rst),
    .cmd_valid(q_nonempty),
    .cmd_op(op_t'(q_dout[PW-1 -: 2])),
    .cmd_fq(q_dout[RW +: QW]),
    .cmd_fr(q_dout[RW-1:0]),
    .cmd_pop(cmd_pop),
    .size_now(size_now),
    .mask_now(mask_now),
    .done(done),
    .outcome(outcome),
    .status(eng_status)
  );

  a_init_busy: assert property (@(posedge clk) disable iff (rst)
    eng_status.init |-> busy)
    else $error("command taken during table sweep");

  a_init_quiet: assert property (@(posedge clk) disable iff (rst)
    eng_status.init |-> !done)
    else $error("result strobed during table sweep");

  a_outcome_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (outcome <= OUT_CLEARED))
    else $error("undefined outcome code");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> (eng_status.idle && q_nonempty))
    else $error("queue popped outside idle");

endmodule
